// ===== rtl/core/i2cm_pkg.sv =====
package i2cm_pkg;

    // item kinds on the command input
    typedef enum logic [1:0] {
        CMD_READ     = 2'd0,
        CMD_WRITE    = 2'd1,
        CMD_BUS_BYTE = 2'd2
    } t_command;

    // command field of the command/data register, bits 10:8
    typedef enum logic [2:0] {
        BC_SEND         = 3'd0,
        BC_RECV         = 3'd1,
        BC_STOP         = 3'd2,
        BC_RECV_DISCARD = 3'd3,
        BC_START        = 3'd4
    } t_bus_cmd;

    // bus request codes on the result
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_START      = 3'd1,
        OP_STOP_START = 3'd2,
        OP_SEND       = 3'd3,
        OP_RECV       = 3'd4,
        OP_STOP       = 3'd5
    } t_bus_op;

    // register offsets
    localparam logic [6:0] OFF_PARAM   = 7'h04;
    localparam logic [6:0] OFF_CONTROL = 7'h10;
    localparam logic [6:0] OFF_STATUS  = 7'h14;
    localparam logic [6:0] OFF_IRQ_EN  = 7'h18;
    localparam logic [6:0] OFF_CONFIG  = 7'h24;
    localparam logic [6:0] OFF_FIFO_ST = 7'h5C;
    localparam logic [6:0] OFF_CMD     = 7'h60;
    localparam logic [6:0] OFF_RXDATA  = 7'h70;

    localparam logic [31:0] RX_EMPTY_MARK = 32'h0000_4000;
    localparam logic [31:0] CTRL_KEEP     = ~32'h0000_0300;
    localparam int          CTRL_RESET    = 1;
    localparam int          CTRL_FIFO_RST = 9;
    localparam int          ST_STOP       = 9;
    localparam int          ST_NACK       = 10;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic fill_step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic fill_start;
        logic fill_last;
    } t_dp_stat;

endpackage

// ===== rtl/core/i2c_master_command_register_block_top.sv =====
// Channel  | Handshake            | Signals
// ---------+----------------------+-----------------------------------------------
// item in  | start & !busy        | i_command i_reg_offset i_write_data i_bus_ack
//          |                      | i_rx_byte
// result   | o_valid (one cycle)  | o_read_data o_bus_op o_bus_address
//          |                      | o_bus_direction o_bus_data o_recv_count o_irq
//
// An item runs through capture, execute and result strobe; busy is high until
// the strobe cycle ends. A receive with no transfer active adds a fill state
// pushing 0xFF bytes one by one, up to RX_DEPTH, since the FIFO has one write port.
// Reset is synchronous, active low, and clears the sequencer, the register file
// and the FIFO count; the item latch and result registers are loaded before use.
// The receiver cannot stall: o_valid is high for the strobe cycle only.
module i2c_master_command_register_block_top #(
    parameter int RX_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [6:0]  i_reg_offset,
    input  logic [31:0] i_write_data,
    input  logic        i_bus_ack,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    output logic [31:0] o_read_data,
    output logic [2:0]  o_bus_op,
    output logic [6:0]  o_bus_address,
    output logic        o_bus_direction,
    output logic [7:0]  o_bus_data,
    output logic [8:0]  o_recv_count,
    output logic        o_irq
);
    import i2cm_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    i2cm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // registers, FIFO and bus request decode
    i2cm_dp #(
        .RX_DEPTH (RX_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_command       (i_command),
        .i_reg_offset    (i_reg_offset),
        .i_write_data    (i_write_data),
        .i_bus_ack       (i_bus_ack),
        .i_rx_byte       (i_rx_byte),
        .o_read_data     (o_read_data),
        .o_bus_op        (o_bus_op),
        .o_bus_address   (o_bus_address),
        .o_bus_direction (o_bus_direction),
        .o_bus_data      (o_bus_data),
        .o_recv_count    (o_recv_count),
        .o_irq           (o_irq)
    );

endmodule

// ===== rtl/core/i2cm_ctrl.sv =====
module i2cm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  i2cm_pkg::t_dp_stat i_stat,
    output i2cm_pkg::t_dp_cmd  o_cmd,
    output logic             o_busy,
    output logic             o_valid
);
    import i2cm_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state         = r_state;
        o_cmd.capture   = 1'b0;
        o_cmd.exec      = 1'b0;
        o_cmd.fill_step = 1'b0;
        o_busy          = 1'b1;
        o_valid         = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.fill_start ? ST_FILL : ST_DONE;
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/i2cm_dp.sv =====
module i2cm_dp #(
    parameter int RX_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  i2cm_pkg::t_dp_cmd  i_cmd,
    output i2cm_pkg::t_dp_stat o_stat,
    input  logic [1:0]       i_command,
    input  logic [6:0]       i_reg_offset,
    input  logic [31:0]      i_write_data,
    input  logic             i_bus_ack,
    input  logic [7:0]       i_rx_byte,
    output logic [31:0]      o_read_data,
    output logic [2:0]       o_bus_op,
    output logic [6:0]       o_bus_address,
    output logic             o_bus_direction,
    output logic [7:0]       o_bus_data,
    output logic [8:0]       o_recv_count,
    output logic             o_irq
);
    import i2cm_pkg::*;

    localparam int PW        = $clog2(RX_DEPTH);
    localparam int FW        = $clog2(RX_DEPTH + 1);
    localparam int LOG_DEPTH = $clog2(RX_DEPTH + 1) - 1;
    localparam logic [31:0] PARAM_WORD = 32'h4 | (32'(LOG_DEPTH) << 8);

    // latched item
    logic [1:0]  r_command;
    logic [6:0]  r_offset;
    logic [31:0] r_wdata;
    logic        r_ack;
    logic [7:0]  r_rx_byte;

    // block state
    logic [31:0] r_control, n_control;
    logic        r_stop_seen, n_stop_seen;
    logic        r_nack_seen, n_nack_seen;
    logic [31:0] r_irq_en, n_irq_en;
    logic [31:0] r_config, n_config;
    logic        r_active, n_active;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FW-1:0] r_fill, n_fill;
    logic [8:0]  r_pending, n_pending;
    logic        r_discard, n_discard;
    logic [8:0]  r_fill_cnt, n_fill_cnt;

    // result
    logic [31:0] r_rd, n_rd;
    logic [2:0]  r_op, n_op;
    logic [6:0]  r_addr, n_addr;
    logic        r_dir, n_dir;
    logic [7:0]  r_bdata, n_bdata;
    logic [8:0]  r_rcnt, n_rcnt;
    logic        r_pop_sel, n_pop_sel;

    // receive FIFO storage
    logic [7:0]  mem [RX_DEPTH];
    logic [7:0]  r_mem_q;

    logic          push_en;
    logic [7:0]    push_data;
    logic          pop_en;
    logic [9:0]    tail_sum;
    logic [9:0]    tail_wrap;
    logic [PW-1:0] tail_idx;
    logic          fifo_full;
    logic [8:0]    space;
    logic [8:0]    recv_n;
    logic [8:0]    fill_req;
    logic [2:0]    bus_cmd;
    logic [7:0]    cmd_data;
    logic [31:0]   status;
    logic [8:0]    fill_ext;
    logic          ptr_last;

    assign bus_cmd   = r_wdata[10:8];
    assign cmd_data  = r_wdata[7:0];
    assign fifo_full = (r_fill == FW'(RX_DEPTH));
    assign fill_ext  = 9'(r_fill);
    assign space     = 9'(RX_DEPTH) - fill_ext;
    assign recv_n    = 9'(cmd_data) + 9'd1;
    assign fill_req  = (recv_n < space) ? recv_n : space;
    assign ptr_last  = (r_rd_ptr == PW'(RX_DEPTH - 1));

    // write slot behind the oldest byte, wrapped once
    assign tail_sum  = 10'(r_rd_ptr) + 10'(r_fill);
    assign tail_wrap = (tail_sum >= 10'(RX_DEPTH)) ? tail_sum - 10'(RX_DEPTH) : tail_sum;
    assign tail_idx  = tail_wrap[PW-1:0];

    // composed status word
    always_comb begin
        status      = 32'h1;
        status[1]   = (r_fill != '0);
        status[ST_STOP] = r_stop_seen;
        status[ST_NACK] = r_nack_seen;
        status[24]  = r_active;
        status[25]  = r_active;
    end

    // idle receive starts a fill sweep
    assign o_stat.fill_start = i_cmd.exec && (r_command == CMD_WRITE) && (r_offset == OFF_CMD)
                               && (bus_cmd == BC_RECV) && !r_active && (fill_req != 9'd0);
    assign o_stat.fill_last  = (r_fill_cnt == 9'd1);

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command <= i_command;
            r_offset  <= i_reg_offset;
            r_wdata   <= i_write_data;
            r_ack     <= i_bus_ack;
            r_rx_byte <= i_rx_byte;
        end
    end

    // item decode and state update
    always_comb begin
        n_control  = r_control;
        n_stop_seen = r_stop_seen;
        n_nack_seen = r_nack_seen;
        n_irq_en   = r_irq_en;
        n_config   = r_config;
        n_active   = r_active;
        n_rd_ptr   = r_rd_ptr;
        n_fill     = r_fill;
        n_pending  = r_pending;
        n_discard  = r_discard;
        n_fill_cnt = r_fill_cnt;
        n_rd       = r_rd;
        n_op       = r_op;
        n_addr     = r_addr;
        n_dir      = r_dir;
        n_bdata    = r_bdata;
        n_rcnt     = r_rcnt;
        n_pop_sel  = r_pop_sel;
        push_en    = 1'b0;
        push_data  = r_rx_byte;
        pop_en     = 1'b0;

        if (i_cmd.exec) begin
            n_rd      = '0;
            n_op      = OP_NONE;
            n_addr    = '0;
            n_dir     = 1'b0;
            n_bdata   = '0;
            n_rcnt    = '0;
            n_pop_sel = 1'b0;
            unique case (r_command)
                CMD_READ: begin
                    unique case (r_offset)
                        OFF_PARAM:   n_rd = PARAM_WORD;
                        OFF_CONTROL: n_rd = r_control;
                        OFF_STATUS:  n_rd = status;
                        OFF_IRQ_EN:  n_rd = r_irq_en;
                        OFF_CONFIG:  n_rd = r_config;
                        OFF_FIFO_ST: n_rd = {8'd0, fill_ext[7:0], 16'd0};
                        OFF_RXDATA: begin
                            if (r_fill == '0) begin
                                n_rd = RX_EMPTY_MARK;
                            end else begin
                                pop_en    = 1'b1;
                                n_pop_sel = 1'b1;
                                n_rd_ptr  = ptr_last ? '0 : r_rd_ptr + PW'(1);
                                n_fill    = r_fill - FW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_WRITE: begin
                    unique case (r_offset)
                        OFF_CONTROL: begin
                            n_control = r_wdata & CTRL_KEEP;
                            if (r_wdata[CTRL_RESET]) begin
                                n_stop_seen = 1'b0;
                                n_nack_seen = 1'b0;
                                n_rd_ptr    = '0;
                                n_fill      = '0;
                                n_active    = 1'b0;
                                n_pending   = '0;
                                n_discard   = 1'b0;
                            end
                            if (r_wdata[CTRL_FIFO_RST]) begin
                                n_rd_ptr = '0;
                                n_fill   = '0;
                            end
                        end
                        OFF_STATUS: begin
                            if (r_wdata[ST_STOP]) n_stop_seen = 1'b0;
                            if (r_wdata[ST_NACK]) n_nack_seen = 1'b0;
                        end
                        OFF_IRQ_EN: n_irq_en = r_wdata;
                        OFF_CONFIG: n_config = r_wdata;
                        OFF_CMD: begin
                            case (bus_cmd)
                                BC_START: begin
                                    n_op      = r_active ? OP_STOP_START : OP_START;
                                    n_addr    = cmd_data[7:1];
                                    n_dir     = cmd_data[0];
                                    n_pending = '0;
                                    n_discard = 1'b0;
                                    if (r_ack) begin
                                        n_active = 1'b1;
                                    end else begin
                                        n_nack_seen = 1'b1;
                                        n_active    = 1'b0;
                                    end
                                end
                                BC_SEND: begin
                                    if (r_active) begin
                                        n_op    = OP_SEND;
                                        n_bdata = cmd_data;
                                        if (!r_ack) n_nack_seen = 1'b1;
                                    end
                                end
                                BC_RECV, BC_RECV_DISCARD: begin
                                    if (r_active) begin
                                        n_op      = OP_RECV;
                                        n_rcnt    = recv_n;
                                        n_pending = recv_n;
                                        n_discard = (bus_cmd == BC_RECV_DISCARD);
                                    end else if (bus_cmd == BC_RECV) begin
                                        n_fill_cnt = fill_req;
                                    end
                                end
                                BC_STOP: begin
                                    if (r_active) begin
                                        n_op     = OP_STOP;
                                        n_active = 1'b0;
                                    end
                                    n_pending   = '0;
                                    n_discard   = 1'b0;
                                    n_stop_seen = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                CMD_BUS_BYTE: begin
                    // bytes with no pending request are dropped
                    if (r_pending != '0) begin
                        n_pending = r_pending - 9'd1;
                        if (!r_discard && !fifo_full) begin
                            push_en = 1'b1;
                            n_fill  = r_fill + FW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end

        // idle receive: one 0xFF byte a cycle
        if (i_cmd.fill_step) begin
            push_data  = 8'hFF;
            n_fill_cnt = r_fill_cnt - 9'd1;
            if (!fifo_full) begin
                push_en = 1'b1;
                n_fill  = r_fill + FW'(1);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control   <= '0;
            r_stop_seen <= 1'b0;
            r_nack_seen <= 1'b0;
            r_irq_en    <= '0;
            r_config    <= '0;
            r_active    <= 1'b0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_pending   <= '0;
            r_discard   <= 1'b0;
            r_fill_cnt  <= '0;
            r_pop_sel   <= 1'b0;
        end else begin
            r_control   <= n_control;
            r_stop_seen <= n_stop_seen;
            r_nack_seen <= n_nack_seen;
            r_irq_en    <= n_irq_en;
            r_config    <= n_config;
            r_active    <= n_active;
            r_rd_ptr    <= n_rd_ptr;
            r_fill      <= n_fill;
            r_pending   <= n_pending;
            r_discard   <= n_discard;
            r_fill_cnt  <= n_fill_cnt;
            r_pop_sel   <= n_pop_sel;
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        r_rd    <= n_rd;
        r_op    <= n_op;
        r_addr  <= n_addr;
        r_dir   <= n_dir;
        r_bdata <= n_bdata;
        r_rcnt  <= n_rcnt;
    end

    // FIFO memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            mem[tail_idx] <= push_data;
        end
        if (pop_en) begin
            r_mem_q <= mem[r_rd_ptr];
        end
    end

    assign o_read_data     = r_pop_sel ? {24'd0, r_mem_q} : r_rd;
    assign o_bus_op        = r_op;
    assign o_bus_address   = r_addr;
    assign o_bus_direction = r_dir;
    assign o_bus_data      = r_bdata;
    assign o_recv_count    = r_rcnt;
    assign o_irq           = ((status & 32'h0000_0603 & r_irq_en) != '0);

endmodule
